/* hdl/metaball_field_and_normal_assert.svh */
`ifndef METABALL_FIELD_AND_NORMAL_ASSERT_SVH
`define METABALL_FIELD_AND_NORMAL_ASSERT_SVH

// Plain invariant, checked on every edge outside reset.
`define MBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: antecedent, then consequent (may carry a delay).
`define MBF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

/* hdl/mbf_pkg.sv */
package mbf_pkg;

  localparam int NUM_BALLS_DEF = 4;
  localparam int MAX_BALLS     = 4;
  localparam int COORD_W       = 16;
  localparam int DIFF_W        = 17;
  localparam int MAG_W         = 16;
  localparam int SQ_W          = 32;
  localparam int DIST_W        = 34;
  localparam int HALF_W        = 17;
  localparam int DIST2_W       = 68;
  localparam int QUO_W         = 41;
  localparam int FNUM_W        = 42;
  localparam int NNUM_W        = 64;
  localparam int R2_W          = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 48;
  localparam int OUT_W         = 32;

  localparam logic [R2_W-1:0]  R2_RESET = 16'd1600;
  localparam logic [QUO_W-1:0] TERM_CAP = 41'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BALL_A = 3'd0,
    REG_BALL_B = 3'd1,
    REG_BALL_C = 3'd2,
    REG_BALL_D = 3'd3,
    REG_RADIUS = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } mbf_in_t;

  typedef struct packed {
    logic        [OUT_W-1:0] field_value;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
  } mbf_out_t;

endpackage

/* hdl/mbf_div.sv */
module mbf_div #(
  parameter int NUM_W = mbf_pkg::NNUM_W,
  parameter int DEN_W = mbf_pkg::DIST2_W,
  parameter int QUO_W = mbf_pkg::QUO_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  `include "metaball_field_and_normal_assert.svh"

  localparam int HI_W = NUM_W - QUO_W;

  logic             valid_q [QUO_W+1];
  logic             ovf_q   [QUO_W+1];
  logic [DEN_W-1:0] rem_q   [QUO_W+1];
  logic [DEN_W-1:0] den_q   [QUO_W+1];
  logic [QUO_W-1:0] lo_q    [QUO_W+1];
  logic [QUO_W-1:0] quo_q   [QUO_W+1];

  logic [DEN_W-1:0] hi_ext;
  assign hi_ext = {{(DEN_W-HI_W){1'b0}}, num_i[NUM_W-1:QUO_W]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0] <= hi_ext >= den_i;
    rem_q[0] <= hi_ext;
    den_q[0] <= den_i;
    lo_q[0]  <= num_i[QUO_W-1:0];
    quo_q[0] <= '0;
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_q[k-1], lo_q[k-1][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[k] <= ovf_q[k-1];
      den_q[k] <= den_q[k-1];
      lo_q[k]  <= {lo_q[k-1][QUO_W-2:0], 1'b0};
      quo_q[k] <= {quo_q[k-1][QUO_W-2:0], ge};
      rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_q[k-1]}) : trial[DEN_W-1:0];
    end
  end

  assign valid_o = valid_q[QUO_W];
  assign quo_o   = quo_q[QUO_W];
  assign ovf_o   = ovf_q[QUO_W];

  `MBF_ASSERT(a_rem_bound, !(valid_q[QUO_W] && !ovf_q[QUO_W]) || (rem_q[QUO_W] < den_q[QUO_W]), "remainder not below divisor")
  `MBF_ASSERT(a_quo_known, !valid_o || !$isunknown(quo_o), "quotient unknown")
  `MBF_ASSERT(a_ovf_known, !valid_o || !$isunknown(ovf_o), "overflow flag unknown")

endmodule

/* hdl/metaball_field_and_normal.sv */
// Metaball field and normal evaluator.
// Input: one vertex per cycle, taken at a rising edge with start_i high and
// busy_o low; busy_o is always low, so a vertex may be offered every cycle.
// Output: done_o is high for one cycle with result_o holding the summed field
// and unnormalised normal; the receiver must take it then.
// Path: offset, square, distance, partial product and stage 5 registers, the
// divider input register and quotient steps, then cap and sign and the result
// register. Throughput: one vertex per clock, fully pipelined; each ball divider
// resolves one quotient bit per stage over 41 stages, which sets the depth.
// Configuration: cfg_we_i writes register cfg_idx_i (ball positions 0 to 3,
// squared radius 4) with cfg_data_i; unknown indexes are ignored. Write only
// while no vertex is in flight.
// Reset clears the pipeline valids, the ball positions to zero and the
// squared radius to 1600; no clearing pass is needed.
module metaball_field_and_normal #(
  parameter int NUM_BALLS = mbf_pkg::NUM_BALLS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  mbf_pkg::mbf_in_t                vertex_i,
  output logic                            done_o,
  output mbf_pkg::mbf_out_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [mbf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mbf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  `include "metaball_field_and_normal_assert.svh"

  localparam int QW  = mbf_pkg::QUO_W;
  localparam int LAT = QW + 8;
  localparam int CW  = mbf_pkg::COORD_W;

  logic [mbf_pkg::CFG_DATA_W-1:0] ball_pos_q [mbf_pkg::MAX_BALLS];
  logic [mbf_pkg::R2_W-1:0]       r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < mbf_pkg::MAX_BALLS; b++) ball_pos_q[b] <= '0;
      r2_q <= mbf_pkg::R2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbf_pkg::REG_BALL_A: ball_pos_q[0] <= cfg_data_i;
        mbf_pkg::REG_BALL_B: ball_pos_q[1] <= cfg_data_i;
        mbf_pkg::REG_BALL_C: ball_pos_q[2] <= cfg_data_i;
        mbf_pkg::REG_BALL_D: ball_pos_q[3] <= cfg_data_i;
        mbf_pkg::REG_RADIUS: r2_q <= cfg_data_i[mbf_pkg::R2_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  logic [CW-1:0] vtx [3];
  assign vtx[0] = vertex_i.vertex_x;
  assign vtx[1] = vertex_i.vertex_y;
  assign vtx[2] = vertex_i.vertex_z;

  // valids
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, cap_v_q, done_q;
  logic div_v;

  // stage 1: offsets
  logic signed [mbf_pkg::DIFF_W-1:0] s1_d_q [NUM_BALLS][3];
  // stage 2: squares and |d| times the squared radius
  logic [mbf_pkg::SQ_W-1:0]  s2_sq_q [NUM_BALLS][3];
  logic [mbf_pkg::SQ_W-1:0]  s2_mr_q [NUM_BALLS][3];
  logic [NUM_BALLS-1:0][2:0] s2_neg_q, s3_neg_q, s4_neg_q, s5_neg_q;
  // stage 3: distance squared
  logic [mbf_pkg::DIST_W-1:0] s3_dist_q [NUM_BALLS];
  logic [mbf_pkg::SQ_W-1:0]   s3_mr_q   [NUM_BALLS][3];
  // stage 4: partial products of distance to the fourth
  logic [mbf_pkg::DIST_W-1:0] s4_hh_q [NUM_BALLS];
  logic [mbf_pkg::DIST_W-1:0] s4_hl_q [NUM_BALLS];
  logic [mbf_pkg::DIST_W-1:0] s4_ll_q [NUM_BALLS];
  logic [mbf_pkg::DIST_W-1:0] s4_dist_q [NUM_BALLS];
  logic [mbf_pkg::SQ_W-1:0]   s4_mr_q   [NUM_BALLS][3];
  // stage 5
  logic [mbf_pkg::DIST2_W-1:0] s5_d2_q   [NUM_BALLS];
  logic [mbf_pkg::DIST_W-1:0]  s5_dist_q [NUM_BALLS];
  logic [mbf_pkg::SQ_W-1:0]    s5_mr_q   [NUM_BALLS][3];

  logic [NUM_BALLS-1:0][2:0] neg_dly_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      cap_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      cap_v_q <= div_v;
      done_q  <= cap_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      for (int a = 0; a < 3; a++) begin
        s1_d_q[b][a] <= $signed({vtx[a][CW-1], vtx[a]})
                      - $signed({ball_pos_q[b][a*CW+CW-1], ball_pos_q[b][a*CW +: CW]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      for (int a = 0; a < 3; a++) begin
        logic [mbf_pkg::DIFF_W-1:0] neg_d;
        logic [mbf_pkg::MAG_W-1:0]  m;
        neg_d = -s1_d_q[b][a];
        m = s1_d_q[b][a][mbf_pkg::DIFF_W-1] ? neg_d[mbf_pkg::MAG_W-1:0]
                                              : s1_d_q[b][a][mbf_pkg::MAG_W-1:0];
        s2_sq_q[b][a]  <= 32'(m) * 32'(m);
        s2_mr_q[b][a]  <= 32'(m) * 32'(r2_q);
        s2_neg_q[b][a] <= s1_d_q[b][a][mbf_pkg::DIFF_W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      logic [mbf_pkg::DIST_W-1:0] sum;
      sum = 34'(s2_sq_q[b][0]) + 34'(s2_sq_q[b][1]) + 34'(s2_sq_q[b][2]);
      s3_dist_q[b] <= (sum == '0) ? 34'd1 : sum;
      for (int a = 0; a < 3; a++) s3_mr_q[b][a] <= s2_mr_q[b][a];
    end
    s3_neg_q <= s2_neg_q;
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      logic [mbf_pkg::HALF_W-1:0] dh, dl;
      dh = s3_dist_q[b][mbf_pkg::DIST_W-1:mbf_pkg::HALF_W];
      dl = s3_dist_q[b][mbf_pkg::HALF_W-1:0];
      s4_hh_q[b]   <= 34'(dh) * 34'(dh);
      s4_hl_q[b]   <= 34'(dh) * 34'(dl);
      s4_ll_q[b]   <= 34'(dl) * 34'(dl);
      s4_dist_q[b] <= s3_dist_q[b];
      for (int a = 0; a < 3; a++) s4_mr_q[b][a] <= s3_mr_q[b][a];
    end
    s4_neg_q <= s3_neg_q;
  end

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      s5_d2_q[b] <= (68'(s4_hh_q[b]) << (2 * mbf_pkg::HALF_W))
                  + (68'(s4_hl_q[b]) << (mbf_pkg::HALF_W + 1))
                  + 68'(s4_ll_q[b]);
      s5_dist_q[b] <= s4_dist_q[b];
      for (int a = 0; a < 3; a++) s5_mr_q[b][a] <= s4_mr_q[b][a];
    end
    s5_neg_q <= s4_neg_q;
  end

  always_ff @(posedge clk_i) begin
    neg_dly_q[0] <= s5_neg_q;
    for (int k = 1; k <= QW; k++) neg_dly_q[k] <= neg_dly_q[k-1];
  end

  // dividers
  logic [QW-1:0] fq [NUM_BALLS];
  logic [QW-1:0] nq [NUM_BALLS][3];
  logic          no [NUM_BALLS][3];
  logic [NUM_BALLS-1:0] fv;
  logic [NUM_BALLS-1:0] fo;
  logic [NUM_BALLS-1:0][2:0] nv;

  for (genvar b = 0; b < NUM_BALLS; b++) begin : g_ball
    mbf_div #(
      .NUM_W(mbf_pkg::FNUM_W),
      .DEN_W(mbf_pkg::DIST_W),
      .QUO_W(QW)
    ) u_fdiv (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(s5_v_q),
      .num_i  ({2'b00, r2_q, 24'd0}),
      .den_i  (s5_dist_q[b]),
      .valid_o(fv[b]),
      .quo_o  (fq[b]),
      .ovf_o  (fo[b])
    );
    for (genvar a = 0; a < 3; a++) begin : g_axis
      mbf_div #(
        .NUM_W(mbf_pkg::NNUM_W),
        .DEN_W(mbf_pkg::DIST2_W),
        .QUO_W(QW)
      ) u_ndiv (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(s5_v_q),
        .num_i  ({s5_mr_q[b][a], 32'd0}),
        .den_i  (s5_d2_q[b]),
        .valid_o(nv[b][a]),
        .quo_o  (nq[b][a]),
        .ovf_o  (no[b][a])
      );
    end
  end

  assign div_v = fv[0];

  // cap and sign the normal terms; field terms are registered as they are
  logic [QW-1:0]       cap_f_q [NUM_BALLS];
  logic signed [QW:0]  cap_n_q [NUM_BALLS][3];

  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NUM_BALLS; b++) begin
      cap_f_q[b] <= fq[b];
      for (int a = 0; a < 3; a++) begin
        logic [QW-1:0] m;
        m = (no[b][a] || nq[b][a] > mbf_pkg::TERM_CAP) ? mbf_pkg::TERM_CAP : nq[b][a];
        cap_n_q[b][a] <= neg_dly_q[QW][b][a] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      end
    end
  end

  // sum and saturate
  mbf_pkg::mbf_out_t result_d, result_q;
  logic [QW+1:0]        fsum;
  logic signed [QW+2:0] nsum [3];
  logic [mbf_pkg::OUT_W-1:0] nsat [3];

  always_comb begin
    fsum = '0;
    for (int a = 0; a < 3; a++) nsum[a] = '0;
    for (int b = 0; b < NUM_BALLS; b++) begin
      fsum = fsum + (QW+2)'(cap_f_q[b]);
      for (int a = 0; a < 3; a++) nsum[a] = nsum[a] + (QW+3)'(cap_n_q[b][a]);
    end
    for (int a = 0; a < 3; a++) begin
      if (nsum[a] > 44'sd2147483647) begin
        nsat[a] = 32'h7FFF_FFFF;
      end else if (nsum[a] < -44'sd2147483648) begin
        nsat[a] = 32'h8000_0000;
      end else begin
        nsat[a] = nsum[a][mbf_pkg::OUT_W-1:0];
      end
    end
    result_d.field_value = (|fsum[QW+1:mbf_pkg::OUT_W]) ? 32'hFFFF_FFFF
                                                       : fsum[mbf_pkg::OUT_W-1:0];
    result_d.normal_x = nsat[0];
    result_d.normal_y = nsat[1];
    result_d.normal_z = nsat[2];
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `MBF_ASSERT_IMPL(a_latency, start_i && !busy_o, ##(LAT) done_o, "accepted item gave no result")
  `MBF_ASSERT_IMPL(a_no_orphan, done_o, $past(start_i && !busy_o, LAT), "result without item")
  `MBF_ASSERT(a_div_sync, (fv == {NUM_BALLS{div_v}}) && (nv == {(3*NUM_BALLS){div_v}}), "dividers out of step")
  `MBF_ASSERT(a_field_no_ovf, !div_v || (fo == '0), "field quotient overflow")

endmodule

/* sim/metaball_field_and_normal_tb.sv */
module metaball_field_and_normal_tb;

  localparam int LATENCY  = 49;
  localparam int WD_LIMIT = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  mbf_pkg::mbf_in_t  vertex_i;
  logic              done_o;
  mbf_pkg::mbf_out_t result_o;
  logic              cfg_we_i;
  logic [mbf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mbf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  metaball_field_and_normal u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .vertex_i(vertex_i), .done_o(done_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  logic [47:0]       ball_pos [4];
  logic [15:0]       radius_sq;
  mbf_pkg::mbf_out_t field_q [$];
  int                mismatches;
  int                idle_cycles;
  bit                timed_out;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint normal_contrib(longint d, logic [63:0] r2, logic [63:0] dist2);
    logic [63:0] m;
    logic [63:0] q;
    m = (d < 0) ? 64'(-d) : 64'(d);
    q = (((m * r2) << 32) / dist2) / dist2;
    if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [31:0] clamp_s32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic mbf_pkg::mbf_out_t field_at(mbf_pkg::mbf_in_t v);
    mbf_pkg::mbf_out_t r;
    logic [63:0]       fsum;
    logic [63:0]       dist2;
    longint            nx, ny, nz, dx, dy, dz;
    fsum = 0; nx = 0; ny = 0; nz = 0;
    for (int i = 0; i < mbf_pkg::NUM_BALLS_DEF; i++) begin
      dx = sx16(v.vertex_x) - sx16(ball_pos[i][15:0]);
      dy = sx16(v.vertex_y) - sx16(ball_pos[i][31:16]);
      dz = sx16(v.vertex_z) - sx16(ball_pos[i][47:32]);
      dist2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      if (dist2 == 0) dist2 = 1;
      fsum += (64'(radius_sq) << 24) / dist2;
      nx += normal_contrib(dx, 64'(radius_sq), dist2);
      ny += normal_contrib(dy, 64'(radius_sq), dist2);
      nz += normal_contrib(dz, 64'(radius_sq), dist2);
    end
    r.field_value = (fsum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fsum[31:0];
    r.normal_x = clamp_s32(nx);
    r.normal_y = clamp_s32(ny);
    r.normal_z = clamp_s32(nz);
    return r;
  endfunction

  always @(posedge clk_i) begin
    mbf_pkg::mbf_out_t e;
    if (rst_ni && done_o) begin
      if (field_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        e = field_q.pop_front();
        if (result_o.field_value !== e.field_value || result_o.normal_x !== e.normal_x ||
            result_o.normal_y !== e.normal_y || result_o.normal_z !== e.normal_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp f=%h n=%h,%h,%h got f=%h n=%h,%h,%h",
                     e.field_value, e.normal_x, e.normal_y, e.normal_z,
                     result_o.field_value, result_o.normal_x, result_o.normal_y,
                     result_o.normal_z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start_i stays high after an accept until a gap before the next item or a drain lowers it
  task automatic send_vertex(mbf_pkg::mbf_in_t v, bit gaps = 1);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) wait_n = 0;
    if (wait_n != 0) begin
      start_i <= 1'b0;
      repeat (wait_n) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    vertex_i <= v;
    do @(posedge clk_i); while (busy_o);
    field_q.push_back(field_at(v));
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (field_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(mbf_pkg::cfg_reg_e idx, logic [47:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mbf_pkg::REG_RADIUS) radius_sq = data[15:0];
    else ball_pos[idx] = data;
    @(posedge clk_i);
  endtask

  function automatic mbf_pkg::mbf_in_t rand_vertex(int span);
    mbf_pkg::mbf_in_t v;
    if (span == 0) v = {16'($urandom), 16'($urandom), 16'($urandom)};
    else v = {16'($urandom_range(0, 2 * span) - span), 16'($urandom_range(0, 2 * span) - span),
              16'($urandom_range(0, 2 * span) - span)};
    return v;
  endfunction

  task automatic test_extremes;
    logic [15:0] ext [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++)
        send_vertex({ext[i], ext[(i + j) % 5], ext[(i + 2 * j) % 5]}, 0);
    drain();
  endtask

  task automatic test_special_cases;
    write_reg(mbf_pkg::REG_BALL_A, 48'h0100_0200_0300);
    write_reg(mbf_pkg::REG_BALL_B, 48'hFF00_FE00_FD00);
    write_reg(mbf_pkg::REG_BALL_C, 48'h7FFF_8000_0001);
    write_reg(mbf_pkg::REG_BALL_D, 48'h0000_0000_0000);
    send_vertex({16'h0300, 16'h0200, 16'h0100});
    send_vertex({16'h0001, 16'h8000, 16'h7FFF});
    send_vertex({16'h0000, 16'h0000, 16'h0001});
    drain();
    write_reg(mbf_pkg::REG_RADIUS, 16'h0000);
    send_vertex({16'h0000, 16'h0000, 16'h0000});
    drain();
    write_reg(mbf_pkg::REG_RADIUS, 16'hFFFF);
    send_vertex({16'h0000, 16'h0000, 16'h0000});
    send_vertex({16'h0000, 16'h0000, 16'h0002});
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd7; cfg_data_i <= '1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_vertex({16'h0010, 16'h0020, 16'h0030});
    drain();
  endtask

  task automatic test_random_sweep(int n);
    for (int p = 0; p < 6; p++) begin
      for (int b = 0; b < 4; b++)
        write_reg(mbf_pkg::cfg_reg_e'(b),
                  (p == 5) ? 48'($urandom_range(0, 3) * 48'h5555_5555_5555) :
                  {16'($urandom), 16'($urandom), 16'($urandom)});
      case (p)
        0: write_reg(mbf_pkg::REG_RADIUS, 16'd1600);
        1: write_reg(mbf_pkg::REG_RADIUS, 16'hFFFF);
        2: write_reg(mbf_pkg::REG_RADIUS, 16'd1);
        default: write_reg(mbf_pkg::REG_RADIUS, 16'($urandom));
      endcase
      for (int k = 0; k < n / 6; k++) begin
        mbf_pkg::mbf_in_t v;
        case ($urandom_range(0, 3))
          0: v = rand_vertex(0);
          1: v = rand_vertex(64);
          2: v = rand_vertex(2048);
          default: begin
            int b;
            b = $urandom_range(0, 3);
            v.vertex_x = ball_pos[b][15:0]  + 16'($urandom_range(0, 8) - 4);
            v.vertex_y = ball_pos[b][31:16] + 16'($urandom_range(0, 8) - 4);
            v.vertex_z = ball_pos[b][47:32] + 16'($urandom_range(0, 8) - 4);
          end
        endcase
        send_vertex(v, k % 200 < 150);
      end
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0; vertex_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    mismatches = 0; timed_out = 1'b0;
    for (int i = 0; i < 4; i++) ball_pos[i] = '0;
    radius_sq = mbf_pkg::R2_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_random_sweep(1320);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && field_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
